>>> design/assert_macros.svh
// Assertion macros shared by the xorshift range generator RTL.
// No dependencies; taken in by `include where a module checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/xrr_pkg.sv
// Shared types and constants for the xorshift range random generator.
// No dependencies; used by the front, queue, back and top modules.
`default_nettype none

package xrr_pkg;

   // Generator constants
   localparam logic [63:0] XS_MULT        = 64'h2545F4914F6CDD1D;
   localparam int unsigned XS_SHIFT_A     = 12;
   localparam int unsigned XS_SHIFT_B     = 25;
   localparam int unsigned XS_SHIFT_C     = 27;
   localparam logic [63:0] SEED_RESET     = 64'd1;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEF = 2;

   // Back-end sequencing
   localparam int unsigned CNT_W          = 6;
   localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(3);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(62);

   // Classification of a request
   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_ONE,
      KIND_RAND
   } kind_type;

   // Command passed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [62:0] bound;
      logic [63:0] seed;
   } cmd_type;

   // Back-end states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } bk_state_type;

endpackage

`default_nettype wire

>>> design/xrr_front.sv
// Front end: takes requests, classifies the bound, advances the xorshift state.
// Depends on xrr_pkg; feeds xrr_queue with commands.
`default_nettype none

`include "assert_macros.svh"

module xrr_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  signed [63:0]    req_max_value,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire         [63:0]    csr_initial_seed,
   input  wire                   q_full,
   output logic                  q_push,
   output xrr_pkg::cmd_type      q_push_data
);

   logic [63:0]       seed_ff;
   logic [63:0]       seed_in;
   logic [63:0]       step_a;
   logic [63:0]       step_b;
   logic [63:0]       step_c;
   xrr_pkg::kind_type kind;
   logic              accept;

   // Seed register is always writable
   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // Classify the bound
   always_comb begin
      if (req_max_value[63] || (req_max_value == 64'sd0)) begin
         kind = xrr_pkg::KIND_ZERO;
      end else if (req_max_value == 64'sd1) begin
         kind = xrr_pkg::KIND_ONE;
      end else begin
         kind = xrr_pkg::KIND_RAND;
      end
   end

   // Advance the xorshift state
   assign step_a = seed_ff ^ (seed_ff >> xrr_pkg::XS_SHIFT_A);
   assign step_b = step_a ^ (step_a << xrr_pkg::XS_SHIFT_B);
   assign step_c = step_b ^ (step_b >> xrr_pkg::XS_SHIFT_C);

   // Build the command for the back end
   always_comb begin
      q_push            = accept;
      q_push_data.kind  = kind;
      q_push_data.bound = req_max_value[62:0];
      q_push_data.seed  = step_c;
   end

   // Seed write wins; otherwise advance only on a random request
   always_comb begin
      seed_in = seed_ff;
      if (csr_valid && csr_ready) begin
         seed_in = csr_initial_seed;
      end else if (accept && (kind == xrr_pkg::KIND_RAND)) begin
         seed_in = step_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= xrr_pkg::SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   `ASSERT_NEXT(a_seed_load, clock, reset, csr_valid && csr_ready, seed_ff == $past(csr_initial_seed), "seed write not taken")

endmodule

`default_nettype wire

>>> design/xrr_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on xrr_pkg for the command type.
`default_nettype none

`include "assert_macros.svh"

module xrr_queue #(
   parameter int unsigned DEPTH = xrr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  xrr_pkg::cmd_type      push_data,
   output logic                  full,
   input  wire                   pop,
   output xrr_pkg::cmd_type      pop_data,
   output logic                  not_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   xrr_pkg::cmd_type   slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = slots_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_IMPL(a_no_overflow, clock, reset, push, !full, "push into full queue")
   `ASSERT_IMPL(a_no_underflow, clock, reset, pop, not_empty, "pop from empty queue")

endmodule

`default_nettype wire

>>> design/xrr_back.sv
// Back end: scrambles the state with a shared 32x32 multiplier, then reduces
// it modulo the bound with a restoring divider. Depends on xrr_pkg.
`default_nettype none

`include "assert_macros.svh"

module xrr_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_not_empty,
   input  xrr_pkg::cmd_type      q_pop_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic        [62:0]    rsp_random_value
);

   xrr_pkg::bk_state_type       state_ff;
   xrr_pkg::bk_state_type       state_in;
   logic [xrr_pkg::CNT_W-1:0]   cnt_ff;
   logic [xrr_pkg::CNT_W-1:0]   cnt_in;
   logic [63:0]                 seed_ff;
   logic [63:0]                 seed_in;
   logic [62:0]                 bound_ff;
   logic [62:0]                 bound_in;
   logic [63:0]                 prod_ff;
   logic [63:0]                 prod_in;
   logic [63:0]                 acc_ff;
   logic [63:0]                 acc_in;
   logic [62:0]                 quot_ff;
   logic [62:0]                 quot_in;
   logic [62:0]                 rem_ff;
   logic [62:0]                 rem_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [62:0]                 rsp_value_ff;
   logic [62:0]                 rsp_value_in;
   logic [31:0]                 op_a;
   logic [31:0]                 op_b;
   logic [63:0]                 trial;
   logic                        out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;
   assign out_free         = !rsp_valid_ff || !rsp_stall;

   // Pick multiplier halves: low*low, low*high, high*low
   assign op_a  = (cnt_ff == xrr_pkg::CNT_W'(2)) ? seed_ff[63:32] : seed_ff[31:0];
   assign op_b  = (cnt_ff == xrr_pkg::CNT_W'(1)) ? xrr_pkg::XS_MULT[63:32]
                                                 : xrr_pkg::XS_MULT[31:0];
   // Shift next dividend bit into the partial remainder
   assign trial = {rem_ff, quot_ff[62]};

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      seed_in      = seed_ff;
      bound_in     = bound_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      q_pop        = 1'b0;
      case (state_ff)
         xrr_pkg::BK_IDLE: begin
            if (q_not_empty) begin
               if (q_pop_data.kind == xrr_pkg::KIND_RAND) begin
                  q_pop    = 1'b1;
                  seed_in  = q_pop_data.seed;
                  bound_in = q_pop_data.bound;
                  cnt_in   = '0;
                  state_in = xrr_pkg::BK_MUL;
               end else if (out_free) begin
                  q_pop        = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_value_in = (q_pop_data.kind == xrr_pkg::KIND_ONE) ? 63'd1 : 63'd0;
               end
            end
         end
         xrr_pkg::BK_MUL: begin
            // Multiply in one step, accumulate the registered product in the next
            prod_in = 64'(op_a) * 64'(op_b);
            if (cnt_ff == xrr_pkg::CNT_W'(1)) begin
               acc_in = prod_ff;
            end else if (cnt_ff != '0) begin
               acc_in = acc_ff + {prod_ff[31:0], 32'h0};
            end
            if (cnt_ff == xrr_pkg::MUL_LAST) begin
               quot_in  = acc_in[62:0];
               rem_in   = '0;
               cnt_in   = '0;
               state_in = xrr_pkg::BK_DIV;
            end else begin
               cnt_in = cnt_ff + xrr_pkg::CNT_W'(1);
            end
         end
         xrr_pkg::BK_DIV: begin
            // One remainder bit per cycle
            if (trial >= {1'b0, bound_ff}) begin
               rem_in = 63'(trial - {1'b0, bound_ff});
            end else begin
               rem_in = trial[62:0];
            end
            quot_in = {quot_ff[61:0], 1'b0};
            if (cnt_ff == xrr_pkg::DIV_LAST) begin
               state_in = xrr_pkg::BK_DONE;
            end else begin
               cnt_in = cnt_ff + xrr_pkg::CNT_W'(1);
            end
         end
         xrr_pkg::BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rem_ff + 63'd1;
               state_in     = xrr_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = xrr_pkg::BK_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xrr_pkg::BK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      seed_ff      <= seed_in;
      bound_ff     <= bound_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      rsp_value_ff <= rsp_value_in;
   end

   `ASSERT_IMPL(a_rem_below_bound, clock, reset, state_ff == xrr_pkg::BK_DIV, rem_ff < bound_ff, "remainder not below bound")
   `ASSERT_IMPL(a_pop_idle, clock, reset, q_pop, state_ff == xrr_pkg::BK_IDLE, "pop outside idle")

endmodule

`default_nettype wire

>>> design/xorshift_range_random_top.sv
// Bounds 1 or less: result goes via the queue and response register; one item per cycle
// while the back end is idle and not stalled. Bound 2 and up: the back end takes one item at
// a time (dispatch, 4 multiply steps on one 32x32 multiplier, 63 divide steps, finish).
// A small queue lets the front accept items while the back end is busy.
// Synchronous active-high reset sets the generator state to 1 and empties the queue.
// Top level: ties front end, queue and back end together; depends on xrr_pkg.
`default_nettype none

module xorshift_range_random_top #(
   parameter int unsigned QUEUE_DEPTH = xrr_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  signed [63:0]    req_max_value,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic        [62:0]    rsp_random_value,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire         [63:0]    csr_initial_seed
);

   logic             q_full;
   logic             q_push;
   xrr_pkg::cmd_type q_push_data;
   logic             q_pop;
   xrr_pkg::cmd_type q_pop_data;
   logic             q_not_empty;

   xrr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_max_value    (req_max_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_initial_seed (csr_initial_seed),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_push_data      (q_push_data)
   );

   xrr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty)
   );

   xrr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_pop_data       (q_pop_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

endmodule

`default_nettype wire
